@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros shared by the RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ src/nmc_pkg.sv @@
// ----------------------------------------------------------------------------
// nmc_pkg
// Shared types and constants for the nonmanifold node check block.
// ----------------------------------------------------------------------------
package nmc_pkg;

  localparam int NODE_W        = 10;
  localparam int NODE_SPAN     = 2 ** NODE_W;
  localparam int TOTAL_W       = NODE_W + 1;
  localparam int REC_W         = 4;
  localparam int MAX_NODES_DEF = 1024;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REASON_NONE     = 2'd0,
    REASON_MANY     = 2'd1,
    REASON_BOUNDARY = 2'd2,
    REASON_ORIENT   = 2'd3
  } reason_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the request
    logic rd_a;       // read record of first node
    logic rd_b;       // read record of second node
    logic wr_a;       // write back first node, bump node total
    logic wr_b;       // write back second node
    logic clr_start;  // reset sweep cursor and node total
    logic clr_wr;     // zero the record at the sweep cursor
    logic emit;       // register a result
  } nmc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  oor;
    logic  self_loop;
    logic  clr_last;
  } nmc_status_t;

endpackage

@@ src/nmc_ram.sv @@
// ----------------------------------------------------------------------------
// nmc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nmc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/nmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// nmc_ctrl
// Sequencer: dispatches a request into read-modify-write, query or clear sweep.
// ----------------------------------------------------------------------------
module nmc_ctrl import nmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  nmc_status_t status,
  output nmc_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DECODE   = 7'b0000010,
    S_LD_A     = 7'b0000100,
    S_LD_B     = 7'b0001000,
    S_QRY      = 7'b0010000,
    S_CLR      = 7'b0100000,
    S_CLR_INIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.mode)
          MODE_LOAD: begin
            if (status.oor) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.rd_a  = 1'b1;
              state_nxt = S_LD_A;
            end
          end
          MODE_QUERY: begin
            if (status.oor) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.rd_a  = 1'b1;
              state_nxt = S_QRY;
            end
          end
          MODE_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR;
          end
          default: begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_LD_A: begin
        cmd.wr_a = 1'b1;
        // a self-loop touches one record, so both incidences land in one write
        if (status.self_loop) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_b  = 1'b1;
          state_nxt = S_LD_B;
        end
      end
      S_LD_B: begin
        cmd.wr_b  = 1'b1;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QRY: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLR_INIT: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/nmc_datapath.sv @@
// ----------------------------------------------------------------------------
// nmc_datapath
// Request registers, node record store, record update, query check, results.
// ----------------------------------------------------------------------------
module nmc_datapath import nmc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic [1:0]         in_mode,
  input  logic [NODE_W-1:0]  in_first_node,
  input  logic [NODE_W-1:0]  in_second_node,
  input  nmc_cmd_t           cmd,
  output nmc_status_t        status,
  output logic               out_valid,
  output logic               out_nonmanifold,
  output logic [1:0]         out_reason,
  output logic [1:0]         out_incidence,
  output logic [TOTAL_W-1:0] out_node_total,
  output logic               out_out_of_range
);

  localparam int DEPTH = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
  localparam int AW    = $clog2(DEPTH);

  // add one incidence to a record: count saturates at 3, start flags
  // are kept for the first two incidences only
  function automatic logic [REC_W-1:0] rec_add(input logic [REC_W-1:0] r,
                                               input logic is_start);
    logic [REC_W-1:0] n;
    n = r;
    if (r[1:0] == 2'd0 && is_start) n[2] = 1'b1;
    if (r[1:0] == 2'd1 && is_start) n[3] = 1'b1;
    if (r[1:0] != 2'd3) n[1:0] = r[1:0] + 2'd1;
    return n;
  endfunction

  mode_t               mode_r;
  logic [NODE_W-1:0]   a_r, b_r;
  logic                oor_r, oor_nxt;
  logic                allow_r;
  logic [AW-1:0]       cursor_r, cursor_nxt;
  logic [TOTAL_W-1:0]  tot_r, tot_nxt, hi;
  logic                clr_last;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [REC_W-1:0]    ram_wdata, ram_rdata;

  logic                valid_r;
  logic                nm_r;
  reason_t             reason_r, reason_nxt;
  logic [1:0]          inc_r, inc_nxt;
  logic [TOTAL_W-1:0]  total_out_r;
  logic                oor_out_r;

  // out of range flag decided at capture time
  always_comb begin
    case (mode_t'(in_mode))
      MODE_LOAD:  oor_nxt = (32'(in_first_node) >= 32'(MAX_NODES)) ||
                            (32'(in_second_node) >= 32'(MAX_NODES));
      MODE_QUERY: oor_nxt = (32'(in_first_node) >= 32'(MAX_NODES));
      default:    oor_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= mode_t'(in_mode);
      a_r    <= in_first_node;
      b_r    <= in_second_node;
      oor_r  <= oor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r <= 1'b0;
    end else if (cfg_we) begin
      allow_r <= cfg_wdata;
    end
  end

  // sweep cursor
  assign clr_last = (cursor_r == AW'(DEPTH - 1));

  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.clr_start) begin
      cursor_nxt = '0;
    end else if (cmd.clr_wr) begin
      cursor_nxt = clr_last ? '0 : cursor_r + AW'(1);
    end
  end

  // node total: largest loaded index plus one
  assign hi = ((a_r > b_r) ? {1'b0, a_r} : {1'b0, b_r}) + TOTAL_W'(1);

  always_comb begin
    tot_nxt = tot_r;
    if (cmd.clr_start) begin
      tot_nxt = '0;
    end else if (cmd.wr_a && (hi > tot_r)) begin
      tot_nxt = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      tot_r    <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      tot_r    <= tot_nxt;
    end
  end

  // record store ports
  always_comb begin
    ram_we    = cmd.wr_a | cmd.wr_b | cmd.clr_wr;
    ram_re    = cmd.rd_a | cmd.rd_b;
    ram_raddr = cmd.rd_b ? b_r[AW-1:0] : a_r[AW-1:0];
    if (cmd.wr_a) begin
      ram_waddr = a_r[AW-1:0];
      ram_wdata = (a_r == b_r) ? rec_add(rec_add(ram_rdata, 1'b1), 1'b1)
                               : rec_add(ram_rdata, 1'b1);
    end else if (cmd.wr_b) begin
      ram_waddr = b_r[AW-1:0];
      ram_wdata = rec_add(ram_rdata, 1'b0);
    end else begin
      ram_waddr = cursor_r;
      ram_wdata = '0;
    end
  end

  nmc_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // query check on the record just read
  always_comb begin
    reason_nxt = REASON_NONE;
    inc_nxt    = 2'd0;
    if (mode_r == MODE_QUERY && !oor_r) begin
      inc_nxt = ram_rdata[1:0];
      if (ram_rdata[1:0] == 2'd3) begin
        reason_nxt = REASON_MANY;
      end else if (ram_rdata[1:0] == 2'd1 && !allow_r) begin
        reason_nxt = REASON_BOUNDARY;
      end else if (ram_rdata[1:0] == 2'd2 && (ram_rdata[2] == ram_rdata[3])) begin
        reason_nxt = REASON_ORIENT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      nm_r        <= (reason_nxt != REASON_NONE);
      reason_r    <= reason_nxt;
      inc_r       <= inc_nxt;
      total_out_r <= tot_nxt;
      oor_out_r   <= oor_r && (mode_r == MODE_LOAD || mode_r == MODE_QUERY);
    end
  end

  assign status.mode      = mode_r;
  assign status.oor       = oor_r;
  assign status.self_loop = (a_r == b_r);
  assign status.clr_last  = clr_last;

  assign out_valid        = valid_r;
  assign out_nonmanifold  = nm_r;
  assign out_reason       = reason_r;
  assign out_incidence    = inc_r;
  assign out_node_total   = total_out_r;
  assign out_out_of_range = oor_out_r;

endmodule

@@ src/nonmanifold_node_check.sv @@
// ----------------------------------------------------------------------------
// nonmanifold_node_check
// Per-node incidence records for a segment mesh, with manifold queries.
// ----------------------------------------------------------------------------
// One request at a time: start is taken when busy is low, and the result
// comes out in the cycle after the last working state, with out_valid high
// for exactly one cycle; it must be captured then, as it is never held.
// Records live in a single-write, registered-read RAM of min(MAX_NODES,
// 1024) entries, and that port sets the timing. Busy is high in the decode
// state alone on an out-of-range or unused request, in decode then check on
// a query, in decode then write on a self-loop load, and on any other load
// through one read, then write-first/read-second, then write. A clear
// sweeps the RAM one entry per cycle after decode; the same sweep runs after
// reset, with busy high and no result. Write cfg_we/cfg_wdata only while no
// request is in flight; the new value applies from the next query.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nonmanifold_node_check import nmc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [NODE_W-1:0]  in_first_node,
  input  logic [NODE_W-1:0]  in_second_node,
  output logic               out_valid,
  output logic               out_nonmanifold,
  output logic [1:0]         out_reason,
  output logic [1:0]         out_incidence,
  output logic [TOTAL_W-1:0] out_node_total,
  output logic               out_out_of_range
);

  nmc_cmd_t    cmd;
  nmc_status_t status;

  nmc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  nmc_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_first_node    (in_first_node),
    .in_second_node   (in_second_node),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_nonmanifold  (out_nonmanifold),
    .out_reason       (out_reason),
    .out_incidence    (out_incidence),
    .out_node_total   (out_node_total),
    .out_out_of_range (out_out_of_range)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPL(a_result_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_IMPL(a_nm_reason, clk, rst_n, out_valid, out_nonmanifold == (out_reason != REASON_NONE))
  `ASSERT_IMPL(a_one_writer, clk, rst_n, 1'b1, $onehot0({cmd.wr_a, cmd.wr_b, cmd.clr_wr}))

endmodule
